// ===== rtl/rfi_pkg.sv =====
// Shared types, constants and fixed-point helpers for the rod frame integrator.
`timescale 1ns / 1ps

package rfi_pkg;

    localparam int MAX_SECTIONS_DEF = 4096;
    localparam int CFG_IDX_W        = 2;
    localparam int OPND_W           = 34;
    localparam int ACC_W            = 66;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE    = 2'd2;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_SUB  = 2'd2;

    localparam logic DS_SQRT = 1'b0;
    localparam logic DS_DIV  = 1'b1;

    localparam logic signed [OPND_W-1:0] ONE30     = 34'sd1073741824;
    localparam logic signed [OPND_W-1:0] PI29      = 34'sd1686629713;
    localparam logic signed [OPND_W-1:0] HALF_PI29 = 34'sd843314857;
    localparam logic signed [OPND_W-1:0] TWO_PI29  = 34'sd3373259426;

    localparam logic signed [OPND_W-1:0] SIN_C [5] = '{
        34'sd178956971, 34'sd8947849, 34'sd213044, 34'sd2959, 34'sd27};
    localparam logic signed [OPND_W-1:0] COS_C [6] = '{
        34'sd536870912, 34'sd44739243, 34'sd1491308, 34'sd26631, 34'sd296, 34'sd2};

    // Negative terms of the Hamilton product, bit = component*4 + q index.
    localparam logic [15:0] QSIGN = 16'h428E;

    typedef struct packed {
        logic signed [31:0] curv_x;
        logic signed [31:0] curv_y;
        logic signed [31:0] curv_z;
        logic               first_section;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic [12:0]        node_index;
        logic               last_node;
    } t_out_item;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_mac_ctrl;

    typedef struct packed {
        logic start;
        logic mode;
    } t_ds_ctrl;

    // Shift right by 30, rounding half away from zero.
    function automatic logic signed [ACC_W-1:0] rshift30(input logic signed [ACC_W-1:0] v);
        logic             neg;
        logic [ACC_W-1:0] mag;
        neg = v[ACC_W-1];
        mag = neg ? ACC_W'(-v) : ACC_W'(v);
        mag = (mag + ACC_W'(1 << 29)) >> 30;
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [ACC_W-1:0] v);
        if (v > 66'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -66'sh8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] clampq(input logic signed [ACC_W-1:0] v);
        if (v > ONE30) begin
            return 32'sd1073741824;
        end else if (v < -ONE30) begin
            return -32'sd1073741824;
        end
        return v[31:0];
    endfunction

endpackage

// ===== rtl/rfi_mac.sv =====
// Shared signed multiply-accumulate unit with a registered product stage.
`timescale 1ns / 1ps

module rfi_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rfi_pkg::t_mac_ctrl                  i_ctrl,
    input  logic signed [rfi_pkg::OPND_W-1:0]   i_a,
    input  logic signed [rfi_pkg::OPND_W-1:0]   i_b,
    output logic signed [rfi_pkg::ACC_W-1:0]    o_acc
);
    import rfi_pkg::*;

    logic signed [2*OPND_W-1:0] prod;
    logic signed [ACC_W-1:0]    r_p;
    logic [1:0]                 r_op;
    logic                       r_pend;
    logic signed [ACC_W-1:0]    r_acc;

    assign prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_ctrl.start;
        end
        r_p  <= prod[ACC_W-1:0];
        r_op <= i_ctrl.op;
        if (r_pend) begin
            case (r_op)
                OP_LOAD: r_acc <= r_p;
                OP_ADD:  r_acc <= r_acc + r_p;
                OP_SUB:  r_acc <= r_acc - r_p;
                default: r_acc <= r_p;
            endcase
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== rtl/rfi_divsqrt.sv =====
// Bit-serial unit: integer square root of 64 bits or 64-by-32 division.
`timescale 1ns / 1ps

module rfi_divsqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rfi_pkg::t_ds_ctrl i_ctrl,
    input  logic [63:0]       i_num,
    input  logic [31:0]       i_den,
    output logic              o_done,
    output logic [31:0]       o_res
);
    import rfi_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic        r_mode;
    logic [4:0]  r_cnt;
    logic [63:0] r_src;
    logic [35:0] r_rem;
    logic [31:0] r_res;
    logic [31:0] r_den;

    logic [35:0] sq_rem2;
    logic [35:0] sq_trial;
    logic [32:0] dv_rem2;

    assign sq_rem2  = {r_rem[33:0], r_src[63:62]};
    assign sq_trial = {2'b00, r_res, 2'b01};
    assign dv_rem2  = {r_rem[31:0], r_src[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_mode <= i_ctrl.mode;
                r_den  <= i_den;
                r_res  <= '0;
                if (i_ctrl.mode == DS_SQRT) begin
                    r_src <= i_num;
                    r_rem <= '0;
                end else begin
                    r_src <= {i_num[31:0], 32'd0};
                    r_rem <= {4'd0, i_num[63:32]};
                end
            end else if (r_busy) begin
                if (r_mode == DS_SQRT) begin
                    r_src <= {r_src[61:0], 2'b00};
                    if (sq_rem2 >= sq_trial) begin
                        r_rem <= sq_rem2 - sq_trial;
                        r_res <= {r_res[30:0], 1'b1};
                    end else begin
                        r_rem <= sq_rem2;
                        r_res <= {r_res[30:0], 1'b0};
                    end
                end else begin
                    r_src <= {r_src[62:0], 1'b0};
                    if (dv_rem2 >= {1'b0, r_den}) begin
                        r_rem <= 36'(dv_rem2 - {1'b0, r_den});
                        r_res <= {r_res[30:0], 1'b1};
                    end else begin
                        r_rem <= 36'(dv_rem2);
                        r_res <= {r_res[30:0], 1'b0};
                    end
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/rod_frame_integrator_top.sv =====
// Top level of the rod frame integrator: sequencer, state and handshakes.
`timescale 1ns / 1ps

// Integrates a rod made of constant-curvature sections. Each input transfer
// carries one section rotation vector (Q4.28); the block turns the frame
// quaternion (Q2.30) by its exponential and moves the node position (Q16.16)
// one section length along the frame x axis, producing one result transfer
// per section node. A transfer flagged first_section restarts the rod at the
// origin with the identity frame and emits the origin node ahead of the
// section node; a zero section count or length leaves the rod inactive and
// produces nothing. The block takes one section at a time through a single
// shared 34x34 multiply-accumulate unit and a bit-serial root/divide unit,
// which serves once for the angle and three times for the axis; a zero angle
// skips the sine, cosine and axis steps, and a first section also needs the
// section length division and the origin node. Configuration writes are taken
// in any cycle but should only be issued while the block is idle.
module rod_frame_integrator_top #(
    parameter int MAX_SECTIONS = rfi_pkg::MAX_SECTIONS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  rfi_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rfi_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rfi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);
    import rfi_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_STEPDIV = 5'd1;
    localparam logic [4:0] S_OUT0    = 5'd2;
    localparam logic [4:0] S_CHECK   = 5'd3;
    localparam logic [4:0] S_SQ      = 5'd4;
    localparam logic [4:0] S_SQRT    = 5'd5;
    localparam logic [4:0] S_X2      = 5'd6;
    localparam logic [4:0] S_SIN     = 5'd7;
    localparam logic [4:0] S_SIN2    = 5'd8;
    localparam logic [4:0] S_SIN3    = 5'd9;
    localparam logic [4:0] S_COS     = 5'd10;
    localparam logic [4:0] S_COS2    = 5'd11;
    localparam logic [4:0] S_EPROD   = 5'd12;
    localparam logic [4:0] S_EDIV    = 5'd13;
    localparam logic [4:0] S_QMUL    = 5'd14;
    localparam logic [4:0] S_COL     = 5'd15;
    localparam logic [4:0] S_STEP    = 5'd16;
    localparam logic [4:0] S_FIN     = 5'd17;

    // Configuration registers
    logic [31:0]              r_total_length;
    logic [12:0]              r_section_count;
    logic                     r_frame_mode;

    // Rod state
    logic signed [31:0]       r_q [4];
    logic signed [31:0]       r_pos [3];
    logic [12:0]              r_idx;
    logic [31:0]              r_step;
    logic                     r_active;

    // Per-section working registers
    logic [4:0]               r_state;
    logic [2:0]               r_k;
    logic [2:0]               r_i;
    logic signed [31:0]       r_c [3];
    logic [31:0]              r_t;
    logic signed [OPND_W-1:0] r_x;
    logic signed [OPND_W-1:0] r_x2;
    logic signed [OPND_W-1:0] r_h;
    logic signed [OPND_W-1:0] r_s;
    logic                     r_negc;
    logic                     r_dneg;
    logic signed [OPND_W-1:0] r_e [4];
    logic signed [31:0]       r_r [4];
    logic signed [31:0]       r_cc;

    // Output register
    logic                     r_ovalid;
    t_out_item                r_out;

    logic [12:0]              cnt_eff;
    logic                     out_free;
    logic                     in_xfer;
    logic                     mac_state;
    logic [2:0]               mac_n;
    logic                     mac_done;
    t_mac_ctrl                mac_ctrl;
    logic signed [OPND_W-1:0] mac_a;
    logic signed [OPND_W-1:0] mac_b;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  rr;
    t_ds_ctrl                 ds_ctrl;
    logic [63:0]              ds_num;
    logic [31:0]              ds_den;
    logic                     ds_done;
    logic [31:0]              ds_res;
    logic signed [31:0]       b_q [4];
    logic signed [OPND_W-1:0] b2 [4];
    logic signed [31:0]       c_sel;
    logic [ACC_W-1:0]         acc_abs;
    logic signed [OPND_W-1:0] fa0;
    logic signed [OPND_W-1:0] fa1;
    logic signed [OPND_W-1:0] fa2;
    logic                     fneg;
    logic signed [OPND_W-1:0] co;
    logic signed [ACC_W-1:0]  pos_sum;

    assign cnt_eff = (32'(r_section_count) > MAX_SECTIONS) ? 13'(MAX_SECTIONS)
                                                            : r_section_count;
    assign out_free    = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // Frame used for the step: before or after this section's rotation.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            b_q[j] = r_frame_mode ? r_r[j] : r_q[j];
            b2[j]  = $signed({b_q[j][31], b_q[j], 1'b0});
        end
    end

    assign c_sel = (r_state == S_SQ) ? r_c[r_k[1:0]] : r_c[r_i[1:0]];

    // Operand selection for the shared multiplier.
    always_comb begin
        mac_state = 1'b1;
        mac_n     = 3'd1;
        mac_a     = '0;
        mac_b     = '0;
        mac_ctrl.op = OP_LOAD;
        case (r_state)
            S_SQ: begin
                mac_n = 3'd3;
                mac_a = OPND_W'(c_sel);
                mac_b = OPND_W'(c_sel);
                mac_ctrl.op = (r_k == 3'd0) ? OP_LOAD : OP_ADD;
            end
            S_X2: begin
                mac_a = r_x;
                mac_b = r_x;
            end
            S_SIN, S_SIN2, S_COS, S_COS2: begin
                mac_a = r_x2;
                mac_b = r_h;
            end
            S_SIN3: begin
                mac_a = r_x;
                mac_b = r_h;
            end
            S_EPROD: begin
                mac_a = r_s;
                mac_b = OPND_W'(c_sel);
            end
            S_QMUL: begin
                mac_n = 3'd4;
                mac_a = OPND_W'(r_q[r_k[1:0]]);
                mac_b = r_e[r_i[1:0] ^ r_k[1:0]];
                if (r_k == 3'd0) begin
                    mac_ctrl.op = OP_LOAD;
                end else begin
                    mac_ctrl.op = QSIGN[{r_i[1:0], r_k[1:0]}] ? OP_SUB : OP_ADD;
                end
            end
            S_COL: begin
                mac_n = 3'd3;
                case ({r_i[1:0], r_k[1:0]})
                    4'b0000: begin mac_a = ONE30; mac_b = ONE30; mac_ctrl.op = OP_LOAD; end
                    4'b0001: begin mac_a = b2[2]; mac_b = OPND_W'(b_q[2]); mac_ctrl.op = OP_SUB; end
                    4'b0010: begin mac_a = b2[3]; mac_b = OPND_W'(b_q[3]); mac_ctrl.op = OP_SUB; end
                    4'b0101: begin mac_a = b2[1]; mac_b = OPND_W'(b_q[2]); mac_ctrl.op = OP_ADD; end
                    4'b0110: begin mac_a = b2[0]; mac_b = OPND_W'(b_q[3]); mac_ctrl.op = OP_ADD; end
                    4'b1001: begin mac_a = b2[1]; mac_b = OPND_W'(b_q[3]); mac_ctrl.op = OP_ADD; end
                    4'b1010: begin mac_a = b2[0]; mac_b = OPND_W'(b_q[2]); mac_ctrl.op = OP_SUB; end
                    default: begin mac_a = '0; mac_b = '0; mac_ctrl.op = OP_LOAD; end
                endcase
            end
            S_STEP: begin
                mac_a = OPND_W'(r_cc);
                mac_b = $signed({2'b00, r_step});
            end
            default: mac_state = 1'b0;
        endcase
        mac_ctrl.start = mac_state && (r_k < mac_n);
        mac_done       = mac_state && (r_k == mac_n + 3'd1);
    end

    rfi_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (acc)
    );

    assign rr      = rshift30(acc);
    assign acc_abs = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    assign pos_sum = ACC_W'(r_pos[r_i[1:0]]) + rr;
    assign co      = ONE30 - rr[OPND_W-1:0];

    // Root, section length and axis divisions share one serial unit.
    always_comb begin
        ds_ctrl.start = 1'b0;
        ds_ctrl.mode  = DS_DIV;
        ds_num        = {32'd0, r_total_length};
        ds_den        = {19'd0, cnt_eff};
        case (r_state)
            S_STEPDIV: ds_ctrl.start = (r_k == 3'd0);
            S_SQ: begin
                ds_ctrl.start = mac_done;
                ds_ctrl.mode  = DS_SQRT;
                ds_num        = acc[63:0];
            end
            S_EPROD: begin
                ds_ctrl.start = mac_done;
                ds_num        = acc_abs[63:0] + {33'd0, r_t[31:1]};
                ds_den        = r_t;
            end
            default: ds_ctrl.start = 1'b0;
        endcase
    end

    rfi_divsqrt u_ds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ds_ctrl),
        .i_num   (ds_num),
        .i_den   (ds_den),
        .o_done  (ds_done),
        .o_res   (ds_res)
    );

    // Wrap the half angle into (-pi, pi], then fold into [-pi/2, pi/2].
    always_comb begin
        fa0  = $signed({2'b00, ds_res});
        fa1  = (fa0 > PI29) ? fa0 - TWO_PI29 : fa0;
        fneg = 1'b0;
        fa2  = fa1;
        if (fa1 > HALF_PI29) begin
            fa2  = PI29 - fa1;
            fneg = 1'b1;
        end else if (fa1 < -HALF_PI29) begin
            fa2  = -PI29 - fa1;
            fneg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_length  <= 32'd65536;
            r_section_count <= 13'd1;
            r_frame_mode    <= 1'b1;
            r_q[0]          <= 32'sd1073741824;
            r_q[1]          <= '0;
            r_q[2]          <= '0;
            r_q[3]          <= '0;
            r_pos[0]        <= '0;
            r_pos[1]        <= '0;
            r_pos[2]        <= '0;
            r_idx           <= '0;
            r_step          <= '0;
            r_active        <= 1'b0;
            r_state         <= S_IDLE;
            r_k             <= '0;
            r_i             <= '0;
            r_ovalid        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TOTAL_LENGTH:  r_total_length  <= i_cfg_data;
                    CFG_SECTION_COUNT: r_section_count <= i_cfg_data[12:0];
                    CFG_FRAME_MODE:    r_frame_mode    <= i_cfg_data[0];
                    default:           r_frame_mode    <= r_frame_mode;
                endcase
            end

            // Drop the output once it transfers; a new load below overrides.
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            // Step counter of the multiplier sequence; each consumer clears it.
            if (mac_state) begin
                r_k <= r_k + 3'd1;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_c[0] <= i_in_data.curv_x;
                        r_c[1] <= i_in_data.curv_y;
                        r_c[2] <= i_in_data.curv_z;
                        r_k    <= '0;
                        if (i_in_data.first_section) begin
                            r_q[0]   <= 32'sd1073741824;
                            r_q[1]   <= '0;
                            r_q[2]   <= '0;
                            r_q[3]   <= '0;
                            r_pos[0] <= '0;
                            r_pos[1] <= '0;
                            r_pos[2] <= '0;
                            r_idx    <= '0;
                            if (cnt_eff == '0 || r_total_length == '0) begin
                                r_active <= 1'b0;
                            end else begin
                                r_state <= S_STEPDIV;
                            end
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_STEPDIV: begin
                    r_k <= 3'd1;
                    if (ds_done) begin
                        r_step   <= ds_res;
                        r_active <= 1'b1;
                        r_state  <= S_OUT0;
                    end
                end
                S_OUT0: begin
                    // Emit the origin node ahead of the first section.
                    if (out_free) begin
                        r_ovalid         <= 1'b1;
                        r_out.pos_x      <= r_pos[0];
                        r_out.pos_y      <= r_pos[1];
                        r_out.pos_z      <= r_pos[2];
                        r_out.quat_w     <= r_q[0];
                        r_out.quat_x     <= r_q[1];
                        r_out.quat_y     <= r_q[2];
                        r_out.quat_z     <= r_q[3];
                        r_out.node_index <= '0;
                        r_out.last_node  <= 1'b0;
                        r_state          <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_k <= '0;
                    if (!r_active) begin
                        r_state <= S_IDLE;
                    end else if (r_idx >= cnt_eff) begin
                        r_active <= 1'b0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (mac_done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_k <= '0;
                    if (ds_done) begin
                        r_t <= ds_res;
                        if (ds_res == '0) begin
                            r_e[0]  <= ONE30;
                            r_e[1]  <= '0;
                            r_e[2]  <= '0;
                            r_e[3]  <= '0;
                            r_i     <= '0;
                            r_state <= S_QMUL;
                        end else begin
                            r_x     <= fa2 <<< 1;
                            r_negc  <= fneg;
                            r_state <= S_X2;
                        end
                    end
                end
                S_X2: begin
                    if (mac_done) begin
                        r_x2    <= rr[OPND_W-1:0];
                        r_h     <= SIN_C[4];
                        r_i     <= 3'd3;
                        r_k     <= '0;
                        r_state <= S_SIN;
                    end
                end
                S_SIN: begin
                    if (mac_done) begin
                        r_h <= OPND_W'(ACC_W'(SIN_C[r_i]) - rr);
                        r_k <= '0;
                        if (r_i == 3'd0) begin
                            r_state <= S_SIN2;
                        end else begin
                            r_i <= r_i - 3'd1;
                        end
                    end
                end
                S_SIN2: begin
                    if (mac_done) begin
                        r_h     <= OPND_W'(ACC_W'(ONE30) - rr);
                        r_k     <= '0;
                        r_state <= S_SIN3;
                    end
                end
                S_SIN3: begin
                    if (mac_done) begin
                        r_s     <= rr[OPND_W-1:0];
                        r_h     <= COS_C[5];
                        r_i     <= 3'd4;
                        r_k     <= '0;
                        r_state <= S_COS;
                    end
                end
                S_COS: begin
                    if (mac_done) begin
                        r_h <= OPND_W'(ACC_W'(COS_C[r_i]) - rr);
                        r_k <= '0;
                        if (r_i == 3'd0) begin
                            r_state <= S_COS2;
                        end else begin
                            r_i <= r_i - 3'd1;
                        end
                    end
                end
                S_COS2: begin
                    if (mac_done) begin
                        r_e[0]  <= r_negc ? -co : co;
                        r_i     <= '0;
                        r_k     <= '0;
                        r_state <= S_EPROD;
                    end
                end
                S_EPROD: begin
                    if (mac_done) begin
                        r_dneg  <= acc[ACC_W-1];
                        r_state <= S_EDIV;
                    end
                end
                S_EDIV: begin
                    r_k <= '0;
                    if (ds_done) begin
                        r_e[2'(r_i + 3'd1)] <= r_dneg ? -$signed({2'b00, ds_res})
                                                      :  $signed({2'b00, ds_res});
                        if (r_i == 3'd2) begin
                            r_i     <= '0;
                            r_state <= S_QMUL;
                        end else begin
                            r_i     <= r_i + 3'd1;
                            r_state <= S_EPROD;
                        end
                    end
                end
                S_QMUL: begin
                    if (mac_done) begin
                        r_r[r_i[1:0]] <= clampq(rr);
                        r_k <= '0;
                        if (r_i == 3'd3) begin
                            r_i     <= '0;
                            r_state <= S_COL;
                        end else begin
                            r_i <= r_i + 3'd1;
                        end
                    end
                end
                S_COL: begin
                    if (mac_done) begin
                        r_cc    <= clamp32(rr);
                        r_k     <= '0;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (mac_done) begin
                        r_pos[r_i[1:0]] <= clamp32(pos_sum);
                        r_k <= '0;
                        if (r_i == 3'd2) begin
                            r_state <= S_FIN;
                        end else begin
                            r_i     <= r_i + 3'd1;
                            r_state <= S_COL;
                        end
                    end
                end
                S_FIN: begin
                    // Commit the new frame and hand the section node over.
                    if (out_free) begin
                        r_ovalid         <= 1'b1;
                        r_out.pos_x      <= r_pos[0];
                        r_out.pos_y      <= r_pos[1];
                        r_out.pos_z      <= r_pos[2];
                        r_out.quat_w     <= r_r[0];
                        r_out.quat_x     <= r_r[1];
                        r_out.quat_y     <= r_r[2];
                        r_out.quat_z     <= r_r[3];
                        r_out.node_index <= r_idx + 13'd1;
                        r_out.last_node  <= ((r_idx + 13'd1) >= cnt_eff);
                        for (int j = 0; j < 4; j++) begin
                            r_q[j] <= r_r[j];
                        end
                        r_idx <= r_idx + 13'd1;
                        if ((r_idx + 13'd1) >= cnt_eff) begin
                            r_active <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
